// ===== sv/iis_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helpers for the index intersection segmenter
// depends on nothing; used by the interfaces, controller, datapath and top level

package iis_pkg;

	// table geometry
	localparam int GLOBAL_CELLS = 4096;
	localparam int LOCAL_CELLS  = 4096;
	localparam int ADDR_W       = 12;
	localparam int POS_W        = 12;
	localparam int CNT_W        = 13;
	localparam int IDX_W        = 13;
	localparam int OP_W         = 3;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 13;

	localparam logic [CNT_W-1:0] GCELLS_LIMIT = CNT_W'(GLOBAL_CELLS);
	localparam logic [CNT_W-1:0] LCELLS_LIMIT = CNT_W'(LOCAL_CELLS);
	localparam logic [CNT_W-1:0] SAT_MAX      = '1;
	localparam logic [CNT_W-1:0] ACTIVE_RESET = CNT_W'(4096);

	// operation codes
	localparam logic [OP_W-1:0] OP_CLEAR       = 3'd0;
	localparam logic [OP_W-1:0] OP_LOAD_LOCAL  = 3'd1;
	localparam logic [OP_W-1:0] OP_LOAD_REMOTE = 3'd2;
	localparam logic [OP_W-1:0] OP_PROBE       = 3'd3;
	localparam logic [OP_W-1:0] OP_FLUSH       = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_REF_REMOTE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CELLS = 1'd1;

	// result kinds
	localparam logic KIND_SEGMENT = 1'b0;
	localparam logic KIND_TOTALS  = 1'b1;

	// local position table entry
	typedef struct packed {
		logic             valid;
		logic [POS_W-1:0] pos;
	} lpos_t;

	// controller to datapath
	typedef struct packed {
		logic in_ready;
		logic sweep;
		logic probe_commit;
		logic flush_seg;
		logic flush_tot;
	} iis_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic            in_valid;
		logic [OP_W-1:0] in_op;
		logic            sweep_last;
		logic            probe_emit;
		logic            run_open;
		logic            out_free;
	} iis_status_t;

	// saturating increment of a 13-bit counter
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] r;
		r = (v == SAT_MAX) ? SAT_MAX : v + CNT_W'(1);
		return r;
	endfunction

endpackage

// ===== sv/iis_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces: input items, results and configuration writes
// depends on iis_pkg

interface iis_item_if;
	logic                                 valid;
	logic                                 ready;
	logic [iis_pkg::OP_W-1:0]             operation;
	logic signed [iis_pkg::IDX_W-1:0]     global_index;

	modport source (output valid, output operation, output global_index, input ready);
	modport sink (input valid, input operation, input global_index, output ready);
endinterface

interface iis_result_if;
	logic                         valid;
	logic                         ready;
	logic                         result_kind;
	logic [iis_pkg::POS_W-1:0]    segment_start;
	logic [iis_pkg::CNT_W-1:0]    segment_length;
	logic [iis_pkg::CNT_W-1:0]    elements_shared;
	logic [iis_pkg::CNT_W-1:0]    segment_total;
	logic                         last_result;

	modport source (output valid, output result_kind, output segment_start,
		output segment_length, output elements_shared, output segment_total,
		output last_result, input ready);
	modport sink (input valid, input result_kind, input segment_start,
		input segment_length, input elements_shared, input segment_total,
		input last_result, output ready);
endinterface

interface iis_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [iis_pkg::CFG_IDX_W-1:0]     index;
	logic [iis_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/iis_ctrl.sv =====
`timescale 1ns / 1ps
// controller state machine: table sweep, idle, probe commit and flush sequencing
// depends on iis_pkg

module iis_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  iis_pkg::iis_status_t st,
	output iis_pkg::iis_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_PROBE = 4'b0100,
		ST_FLUSH = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// commands from the current state
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.sweep = 1'b1;
			end
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
			end
			ST_PROBE: begin
				cmd.probe_commit = !st.probe_emit || st.out_free;
			end
			ST_FLUSH: begin
				cmd.flush_seg = st.run_open && st.out_free;
				cmd.flush_tot = !st.run_open && st.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (st.sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (st.in_valid) begin
					unique case (st.in_op)
						iis_pkg::OP_CLEAR: state_d = ST_CLEAR;
						iis_pkg::OP_PROBE: state_d = ST_PROBE;
						iis_pkg::OP_FLUSH: state_d = ST_FLUSH;
						default:           state_d = ST_IDLE;
					endcase
				end
			end
			ST_PROBE: begin
				if (cmd.probe_commit) state_d = ST_IDLE;
			end
			ST_FLUSH: begin
				if (cmd.flush_tot) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// state register, sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/iis_datapath.sv =====
`timescale 1ns / 1ps
// datapath: config registers, position and presence tables, run tracking, result register
// depends on iis_pkg and the channel interfaces

module iis_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	iis_item_if.sink             items,
	iis_result_if.source         results,
	iis_cfg_if.sink              cfg,
	input  iis_pkg::iis_cmd_t    cmd,
	output iis_pkg::iis_status_t st
);

	localparam int ADDR_W = iis_pkg::ADDR_W;
	localparam int POS_W  = iis_pkg::POS_W;
	localparam int CNT_W  = iis_pkg::CNT_W;

	// tables
	iis_pkg::lpos_t local_mem [iis_pkg::GLOBAL_CELLS];
	logic           remote_mem [iis_pkg::GLOBAL_CELLS];

	// config registers
	logic             ref_remote_q;
	logic [CNT_W-1:0] active_cells_q;

	// counters and run state
	logic [ADDR_W-1:0] sweep_cnt_q;
	logic [CNT_W-1:0]  llc_q;
	logic [CNT_W-1:0]  probe_cnt_q;
	logic [POS_W-1:0]  prev_pos_q;
	logic              run_open_q;
	logic [POS_W-1:0]  run_start_q;
	logic [CNT_W-1:0]  run_len_q;
	logic [CNT_W-1:0]  shared_q;
	logic [CNT_W-1:0]  run_cnt_q;

	// probe read stage
	iis_pkg::lpos_t lrd_q;
	logic           rrd_q;
	logic           ok_q;

	// result register
	logic             out_valid_q;
	logic             out_kind_q;
	logic [POS_W-1:0] out_start_q;
	logic [CNT_W-1:0] out_len_q;
	logic [CNT_W-1:0] out_shared_q;
	logic [CNT_W-1:0] out_total_q;
	logic             out_last_q;

	logic              accept;
	logic [ADDR_W-1:0] in_addr;
	logic              in_ok;
	logic              llc_room;
	logic              probe_room;
	logic              proceed;
	logic              hit;
	logic              counted;
	logic [POS_W-1:0]  pos;
	logic              contig;
	logic              probe_emit;
	logic              out_free;
	logic              load_seg;

	// request decode and index check
	assign accept   = items.valid && cmd.in_ready;
	assign in_addr  = items.global_index[ADDR_W-1:0];
	assign in_ok    = !items.global_index[iis_pkg::IDX_W-1]
		&& ({1'b0, in_addr} < active_cells_q)
		&& ({1'b0, in_addr} < iis_pkg::GCELLS_LIMIT);
	assign llc_room   = llc_q < iis_pkg::LCELLS_LIMIT;
	assign probe_room = probe_cnt_q < iis_pkg::LCELLS_LIMIT;

	// probe evaluation on the registered table read
	assign hit     = ok_q && lrd_q.valid && rrd_q;
	assign proceed = ref_remote_q || probe_room;
	assign pos     = ref_remote_q ? lrd_q.pos : probe_cnt_q[POS_W-1:0];
	assign counted = proceed && hit;
	assign contig  = run_open_q && ({1'b0, pos} == ({1'b0, prev_pos_q} + CNT_W'(1)));
	assign probe_emit = counted && run_open_q && !contig;

	assign out_free = !out_valid_q || results.ready;
	assign load_seg = (cmd.probe_commit && probe_emit) || cmd.flush_seg;

	// status to controller
	always_comb begin
		st.in_valid   = items.valid;
		st.in_op      = items.operation;
		st.sweep_last = &sweep_cnt_q;
		st.probe_emit = probe_emit;
		st.run_open   = run_open_q;
		st.out_free   = out_free;
	end

	assign items.ready = cmd.in_ready;
	assign cfg.ready   = 1'b1;

	// local position table: sweep, local load, probe read
	always_ff @(posedge clk) begin
		if (cmd.sweep) begin
			local_mem[sweep_cnt_q] <= '0;
		end else if (accept && items.operation == iis_pkg::OP_LOAD_LOCAL && in_ok && llc_room) begin
			local_mem[in_addr] <= '{valid: 1'b1, pos: llc_q[POS_W-1:0]};
		end
		if (accept && items.operation == iis_pkg::OP_PROBE) begin
			lrd_q <= local_mem[in_addr];
		end
	end

	// remote presence table: sweep, remote load, probe read
	always_ff @(posedge clk) begin
		if (cmd.sweep) begin
			remote_mem[sweep_cnt_q] <= 1'b0;
		end else if (accept && items.operation == iis_pkg::OP_LOAD_REMOTE && in_ok) begin
			remote_mem[in_addr] <= 1'b1;
		end
		if (accept && items.operation == iis_pkg::OP_PROBE) begin
			rrd_q <= remote_mem[in_addr];
			ok_q  <= in_ok;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_remote_q   <= 1'b0;
			active_cells_q <= iis_pkg::ACTIVE_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				iis_pkg::CFG_REF_REMOTE:   ref_remote_q   <= cfg.data[0];
				iis_pkg::CFG_ACTIVE_CELLS: active_cells_q <= cfg.data;
				default:                   ref_remote_q   <= ref_remote_q;
			endcase
		end
	end

	// counters and run tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_cnt_q <= '0;
			llc_q       <= '0;
			probe_cnt_q <= '0;
			prev_pos_q  <= '0;
			run_open_q  <= 1'b0;
			run_start_q <= '0;
			run_len_q   <= '0;
			shared_q    <= '0;
			run_cnt_q   <= '0;
		end else begin
			if (cmd.sweep) begin
				sweep_cnt_q <= sweep_cnt_q + ADDR_W'(1);
			end
			if (accept && items.operation == iis_pkg::OP_CLEAR) begin
				sweep_cnt_q <= '0;
				llc_q       <= '0;
				probe_cnt_q <= '0;
				prev_pos_q  <= '0;
				run_open_q  <= 1'b0;
				run_start_q <= '0;
				run_len_q   <= '0;
				shared_q    <= '0;
				run_cnt_q   <= '0;
			end
			if (accept && items.operation == iis_pkg::OP_LOAD_LOCAL && llc_room) begin
				llc_q <= llc_q + CNT_W'(1);
			end
			if (cmd.probe_commit) begin
				if (!ref_remote_q && probe_room) begin
					probe_cnt_q <= probe_cnt_q + CNT_W'(1);
				end
				if (counted) begin
					shared_q   <= iis_pkg::sat_inc(shared_q);
					prev_pos_q <= pos;
					if (contig) begin
						run_len_q <= iis_pkg::sat_inc(run_len_q);
					end else begin
						run_open_q  <= 1'b1;
						run_start_q <= pos;
						run_len_q   <= CNT_W'(1);
						run_cnt_q   <= iis_pkg::sat_inc(run_cnt_q);
					end
				end
			end
			// open segment goes out first, the run closes
			if (cmd.flush_seg) begin
				run_open_q <= 1'b0;
			end
			if (cmd.flush_tot) begin
				run_open_q  <= 1'b0;
				run_start_q <= '0;
				run_len_q   <= '0;
				probe_cnt_q <= '0;
				shared_q    <= '0;
				run_cnt_q   <= '0;
				prev_pos_q  <= '0;
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_seg || cmd.flush_tot) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (load_seg) begin
			out_kind_q   <= iis_pkg::KIND_SEGMENT;
			out_start_q  <= run_start_q;
			out_len_q    <= run_len_q;
			out_shared_q <= '0;
			out_total_q  <= '0;
			out_last_q   <= 1'b0;
		end else if (cmd.flush_tot) begin
			out_kind_q   <= iis_pkg::KIND_TOTALS;
			out_start_q  <= '0;
			out_len_q    <= '0;
			out_shared_q <= shared_q;
			out_total_q  <= run_cnt_q;
			out_last_q   <= 1'b1;
		end
	end

	assign results.valid           = out_valid_q;
	assign results.result_kind     = out_kind_q;
	assign results.segment_start   = out_start_q;
	assign results.segment_length  = out_len_q;
	assign results.elements_shared = out_shared_q;
	assign results.segment_total   = out_total_q;
	assign results.last_result     = out_last_q;

endmodule

// ===== sv/index_intersection_segmenter.sv =====
`timescale 1ns / 1ps
// top level of the index intersection segmenter: controller plus datapath
// depends on iis_pkg, the channel interfaces, iis_ctrl and iis_datapath
//
//  channel   dir  payload                                          request when
//  items     in   operation, global_index                          valid && ready
//  results   out  result_kind, segment_start, segment_length,      valid && ready
//                 elements_shared, segment_total, last_result
//  cfg       in   index, data                                      valid && ready
//
// loads finish in the idle state; a probe is judged on the registered table read
// a flush sends out the open segment, if any, and then the totals
// clear and reset sweep all 4096 entries of both tables, one a cycle, with items held off
// items are taken while a result waits; a probe that closes a segment holds while the result
// register is full, as does a flush; cfg is always ready

module index_intersection_segmenter (
	input  logic         clk,
	input  logic         arst_n,
	iis_item_if.sink     items,
	iis_result_if.source results,
	iis_cfg_if.sink      cfg
);

	iis_pkg::iis_cmd_t    cmd;
	iis_pkg::iis_status_t st;

	// sequencing
	iis_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	// tables, counters and result register
	iis_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.results (results),
		.cfg     (cfg),
		.cmd     (cmd),
		.st      (st)
	);

endmodule

// ===== sim/tb_index_intersection_segmenter.sv =====
`timescale 1ns / 1ps
// testbench for index_intersection_segmenter: directed, cell limit and random request
// streams, every descriptor record checked against an in-bench prediction of the block
// depends on iis_pkg, the channel interfaces in iis_if.sv and the segmenter rtl

module tb_index_intersection_segmenter;

	localparam int DRAIN_CAP   = 20000;
	localparam int RANDOM_REQS = 400;

	typedef struct packed {
		logic                      kind;
		logic [iis_pkg::POS_W-1:0] start;
		logic [iis_pkg::CNT_W-1:0] len;
		logic [iis_pkg::CNT_W-1:0] shared;
		logic [iis_pkg::CNT_W-1:0] total;
		logic                      last;
	} desc_rec_t;

	logic clk;
	logic arst_n;

	iis_item_if   items();
	iis_result_if results();
	iis_cfg_if    cfg();

	index_intersection_segmenter u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.results (results),
		.cfg     (cfg)
	);

	// predicted block state
	logic [iis_pkg::POS_W-1:0] pos_of_cell [iis_pkg::GLOBAL_CELLS];
	bit                        pos_known   [iis_pkg::GLOBAL_CELLS];
	bit                        remote_has  [iis_pkg::GLOBAL_CELLS];
	int unsigned      loaded_locals;
	int unsigned      probe_ordinal;
	int unsigned      last_pos;
	int unsigned      open_start;
	int unsigned      open_len;
	int unsigned      shared_cells;
	int unsigned      run_total;
	bit               run_active;
	bit               probe_remote;
	int unsigned      cell_limit;
	desc_rec_t        descriptor_q [$];

	// run bookkeeping
	int errors        = 0;
	int requests_sent = 0;
	int records_seen  = 0;
	int clears_sent   = 0;
	int phases_run    = 0;
	bit no_idle       = 1'b0;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		#60_000_000;
		$display("index_intersection_segmenter: mismatch");
		$finish;
	end

	// gap length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 24);
	endfunction

	function automatic int any_gidx();
		return int'($urandom_range(0, 4096)) - 1;
	endfunction

	function automatic int unsigned bump(input int unsigned v);
		return (v < iis_pkg::SAT_MAX) ? v + 1 : iis_pkg::SAT_MAX;
	endfunction

	function automatic void wipe_tables();
		foreach (pos_known[i]) begin
			pos_known[i]   = 1'b0;
			remote_has[i]  = 1'b0;
			pos_of_cell[i] = '0;
		end
		loaded_locals = 0;
		probe_ordinal = 0;
		last_pos      = 0;
		run_active    = 1'b0;
		open_start    = 0;
		open_len      = 0;
		shared_cells  = 0;
		run_total     = 0;
	endfunction

	// null, out of range and beyond the active cells are all unusable
	function automatic bit cell_usable(input logic [iis_pkg::IDX_W-1:0] raw,
		output int unsigned g);
		g = 0;
		if (raw[iis_pkg::IDX_W-1])
			return 1'b0;
		if (raw >= cell_limit || raw >= iis_pkg::GLOBAL_CELLS)
			return 1'b0;
		g = raw;
		return 1'b1;
	endfunction

	function automatic void queue_record(input logic kind, input int unsigned start,
		input int unsigned len, input int unsigned shared, input int unsigned total,
		input logic last);
		desc_rec_t r;
		r.kind   = kind;
		r.start  = iis_pkg::POS_W'(start);
		r.len    = iis_pkg::CNT_W'(len);
		r.shared = iis_pkg::CNT_W'(shared);
		r.total  = iis_pkg::CNT_W'(total);
		r.last   = last;
		descriptor_q = {descriptor_q, r};
	endfunction

	// advance the predicted state by one accepted request
	function automatic void predict_request(input logic [iis_pkg::OP_W-1:0] op,
		input logic [iis_pkg::IDX_W-1:0] raw);
		int unsigned g;
		int unsigned pos;
		bit ok;
		bit hit;
		bit counted;
		ok = cell_usable(raw, g);
		case (op)
			iis_pkg::OP_CLEAR: wipe_tables();
			iis_pkg::OP_LOAD_LOCAL: begin
				if (loaded_locals < iis_pkg::LOCAL_CELLS) begin
					if (ok) begin
						pos_of_cell[g] = iis_pkg::POS_W'(loaded_locals);
						pos_known[g]   = 1'b1;
					end
					loaded_locals++;
				end
			end
			iis_pkg::OP_LOAD_REMOTE: begin
				if (ok)
					remote_has[g] = 1'b1;
			end
			iis_pkg::OP_PROBE: begin
				hit     = ok && pos_known[g] && remote_has[g];
				counted = 1'b1;
				pos     = 0;
				if (probe_remote) begin
					pos = ok ? pos_of_cell[g] : 0;
				end else if (probe_ordinal < iis_pkg::LOCAL_CELLS) begin
					pos = probe_ordinal;
					probe_ordinal++;
				end else begin
					counted = 1'b0;
				end
				if (counted && hit) begin
					shared_cells = bump(shared_cells);
					if (run_active && pos == last_pos + 1) begin
						open_len = bump(open_len);
					end else begin
						if (run_active)
							queue_record(iis_pkg::KIND_SEGMENT, open_start, open_len,
								0, 0, 1'b0);
						run_active = 1'b1;
						open_start = pos;
						open_len   = 1;
						run_total  = bump(run_total);
					end
					last_pos = pos;
				end
			end
			iis_pkg::OP_FLUSH: begin
				if (run_active)
					queue_record(iis_pkg::KIND_SEGMENT, open_start, open_len, 0, 0, 1'b0);
				queue_record(iis_pkg::KIND_TOTALS, 0, 0, shared_cells, run_total, 1'b1);
				run_active    = 1'b0;
				open_start    = 0;
				open_len      = 0;
				probe_ordinal = 0;
				shared_cells  = 0;
				run_total     = 0;
				last_pos      = 0;
			end
			default: ;
		endcase
	endfunction

	// one request on the item channel; predicted at the accepting edge
	task automatic send_request(input logic [iis_pkg::OP_W-1:0] op, input int gidx);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			items.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items.valid        <= 1'b1;
		items.operation    <= op;
		items.global_index <= iis_pkg::IDX_W'(gidx);
		do @(posedge clk); while (!items.ready);
		predict_request(op, iis_pkg::IDX_W'(gidx));
		requests_sent++;
		if (op == iis_pkg::OP_CLEAR)
			clears_sent++;
	endtask

	// stop sending and let every predicted record come out
	task automatic wait_drained(input bit until_ready);
		int waited;
		items.valid <= 1'b0;
		waited = 0;
		while (descriptor_q.size() != 0 && waited < DRAIN_CAP) begin
			@(posedge clk);
			waited++;
		end
		if (descriptor_q.size() != 0) begin
			errors++;
			$display("%0t: %0d expected records never arrived", $time, descriptor_q.size());
			descriptor_q.delete();
		end
		repeat (8) @(posedge clk);
		// a table sweep holds the item channel off
		if (until_ready) begin
			waited = 0;
			while (!items.ready && waited < DRAIN_CAP) begin
				@(posedge clk);
				waited++;
			end
			if (!items.ready) begin
				errors++;
				$display("%0t: item channel never became ready", $time);
			end
		end
	endtask

	task automatic write_register(input logic [iis_pkg::CFG_IDX_W-1:0] which,
		input logic [iis_pkg::CFG_DATA_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= which;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (which == iis_pkg::CFG_REF_REMOTE)
			probe_remote = value[0];
		else
			cell_limit = value;
		@(posedge clk);
	endtask

	// settle the block, then write both registers
	task automatic set_mode(input bit ref_remote, input int unsigned cells);
		logic [iis_pkg::CFG_DATA_W-1:0] mode_word;
		mode_word    = iis_pkg::CFG_DATA_W'($urandom);
		mode_word[0] = ref_remote;
		wait_drained(1'b1);
		write_register(iis_pkg::CFG_REF_REMOTE, mode_word);
		write_register(iis_pkg::CFG_ACTIVE_CELLS, iis_pkg::CFG_DATA_W'(cells));
	endtask

	// result channel: random back-pressure
	initial begin
		int hold;
		hold = 0;
		results.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				results.ready <= 1'b0;
			end else begin
				hold = pick_gap();
				results.ready <= (hold == 0);
				if (hold > 0)
					hold--;
			end
		end
	end

	// compare every accepted record with the oldest prediction
	always @(posedge clk) begin
		desc_rec_t want;
		string     diff;
		if (arst_n && results.valid && results.ready) begin
			if (descriptor_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected record kind=%0d start=%0d length=%0d %s%0d %s%0d %s%0d",
					$time, results.result_kind, results.segment_start,
					results.segment_length, "shared=", results.elements_shared,
					"total=", results.segment_total, "last=", results.last_result);
			end else begin
				want = descriptor_q.pop_front();
				records_seen++;
				diff = "";
				if (results.result_kind !== want.kind)
					diff = {diff, " result_kind"};
				if (results.segment_start !== want.start)
					diff = {diff, " segment_start"};
				if (results.segment_length !== want.len)
					diff = {diff, " segment_length"};
				if (results.elements_shared !== want.shared)
					diff = {diff, " elements_shared"};
				if (results.segment_total !== want.total)
					diff = {diff, " segment_total"};
				if (results.last_result !== want.last)
					diff = {diff, " last_result"};
				if (diff != "") begin
					errors++;
					$display("%0t: record differs in%s", $time, diff);
					$display("  expected kind=%0d start=%0d length=%0d shared=%0d total=%0d last=%0d",
						want.kind, want.start, want.len, want.shared, want.total, want.last);
					$display("  actual   kind=%0d start=%0d length=%0d shared=%0d total=%0d last=%0d",
						results.result_kind, results.segment_start, results.segment_length,
						results.elements_shared, results.segment_total, results.last_result);
				end
			end
		end
	end

	// field extremes, duplicates, nulls, undefined operations, both probe modes
	task automatic test_directed();
		set_mode(1'b0, 4096);
		send_request(iis_pkg::OP_LOAD_LOCAL, 0);
		send_request(iis_pkg::OP_LOAD_LOCAL, 4095);
		send_request(iis_pkg::OP_LOAD_LOCAL, -1);
		send_request(iis_pkg::OP_LOAD_LOCAL, 5);
		send_request(iis_pkg::OP_LOAD_LOCAL, 6);
		// duplicate index, the later position wins
		send_request(iis_pkg::OP_LOAD_LOCAL, 5);
		send_request(iis_pkg::OP_LOAD_REMOTE, 0);
		send_request(iis_pkg::OP_LOAD_REMOTE, 4095);
		send_request(iis_pkg::OP_LOAD_REMOTE, 6);
		send_request(iis_pkg::OP_LOAD_REMOTE, 5);
		send_request(iis_pkg::OP_LOAD_REMOTE, -1);
		send_request(iis_pkg::OP_LOAD_REMOTE + 3'd3, 0);
		send_request(iis_pkg::OP_LOAD_REMOTE + 3'd4, 4095);
		send_request(iis_pkg::OP_LOAD_REMOTE + 3'd5, -1);
		// probes follow the local list order
		send_request(iis_pkg::OP_PROBE, 0);
		send_request(iis_pkg::OP_PROBE, 4095);
		send_request(iis_pkg::OP_PROBE, -1);
		send_request(iis_pkg::OP_PROBE, 5);
		send_request(iis_pkg::OP_PROBE, 6);
		send_request(iis_pkg::OP_PROBE, 9);
		send_request(iis_pkg::OP_FLUSH, 0);
		// flush with nothing open gives totals only
		send_request(iis_pkg::OP_FLUSH, -1);
		// probes looked up through the local position table
		set_mode(1'b1, 4096);
		send_request(iis_pkg::OP_PROBE, 6);
		send_request(iis_pkg::OP_PROBE, 5);
		send_request(iis_pkg::OP_PROBE, 0);
		send_request(iis_pkg::OP_PROBE, -1);
		send_request(iis_pkg::OP_PROBE, 4095);
		send_request(iis_pkg::OP_FLUSH, 4095);
	endtask

	// indices at and above the active cell count are ignored
	task automatic test_cell_limit();
		send_request(iis_pkg::OP_CLEAR, 0);
		set_mode(1'b1, 1);
		send_request(iis_pkg::OP_LOAD_LOCAL, 0);
		send_request(iis_pkg::OP_LOAD_LOCAL, 1);
		send_request(iis_pkg::OP_LOAD_LOCAL, 4095);
		send_request(iis_pkg::OP_LOAD_REMOTE, 0);
		send_request(iis_pkg::OP_LOAD_REMOTE, 1);
		send_request(iis_pkg::OP_LOAD_REMOTE, 4095);
		send_request(iis_pkg::OP_PROBE, 0);
		send_request(iis_pkg::OP_PROBE, 1);
		send_request(iis_pkg::OP_FLUSH, 0);
		send_request(iis_pkg::OP_CLEAR, -1);
		set_mode(1'b0, 4095);
		send_request(iis_pkg::OP_LOAD_LOCAL, 4094);
		send_request(iis_pkg::OP_LOAD_LOCAL, 4095);
		send_request(iis_pkg::OP_LOAD_REMOTE, 4094);
		send_request(iis_pkg::OP_LOAD_REMOTE, 4095);
		send_request(iis_pkg::OP_PROBE, 4094);
		send_request(iis_pkg::OP_PROBE, 4095);
		set_mode(1'b0, 4096);
		send_request(iis_pkg::OP_PROBE, 4095);
		send_request(iis_pkg::OP_FLUSH, 0);
	endtask

	// occasional stray request between the well-formed ones
	task automatic maybe_noise();
		if ($urandom_range(0, 99) < 8)
			send_request(iis_pkg::OP_W'($urandom_range(1, 7)), any_gidx());
	endtask

	// one load/probe/flush sequence with random content
	task automatic random_sequence();
		int n;
		int k;
		int r;
		int gidx;
		int tmp;
		int j;
		int local_list [$];
		int probe_list [$];
		n    = $urandom_range(3, 18);
		gidx = (cell_limit > 40) ? $urandom_range(0, cell_limit - 1)
		                         : $urandom_range(0, cell_limit + 2);
		for (k = 0; k < n; k++) begin
			r = $urandom_range(0, 9);
			if (r == 0) begin
				local_list = {local_list, any_gidx()};
			end else begin
				if (r == 1)
					gidx++;
				local_list = {local_list, gidx % iis_pkg::GLOBAL_CELLS};
				gidx++;
			end
		end
		foreach (local_list[i]) begin
			send_request(iis_pkg::OP_LOAD_LOCAL, local_list[i]);
			if (!probe_remote)
				probe_list = {probe_list, local_list[i]};
			maybe_noise();
		end
		foreach (local_list[i]) begin
			if ($urandom_range(0, 9) < 7) begin
				send_request(iis_pkg::OP_LOAD_REMOTE, local_list[i]);
				if (probe_remote)
					probe_list = {probe_list, local_list[i]};
			end
			if ($urandom_range(0, 9) == 0)
				send_request(iis_pkg::OP_LOAD_REMOTE, any_gidx());
		end
		// break some runs
		if (probe_list.size() > 1 && $urandom_range(0, 4) == 0) begin
			k   = $urandom_range(0, probe_list.size() - 1);
			j   = $urandom_range(0, probe_list.size() - 1);
			tmp = probe_list[k];
			probe_list[k] = probe_list[j];
			probe_list[j] = tmp;
		end
		foreach (probe_list[i]) begin
			send_request(iis_pkg::OP_PROBE,
				($urandom_range(0, 9) == 0) ? any_gidx() : probe_list[i]);
			maybe_noise();
		end
		// the sender sometimes holds off until every record is out
		if ($urandom_range(0, 99) < 15)
			wait_drained(1'b0);
		if ($urandom_range(0, 99) < 85)
			send_request(iis_pkg::OP_FLUSH, any_gidx());
	endtask

	task automatic test_random_traffic();
		int first_req;
		int unsigned cells;
		first_req = requests_sent;
		while (requests_sent - first_req < RANDOM_REQS) begin
			if (phases_run % 3 == 0)
				send_request(iis_pkg::OP_CLEAR, any_gidx());
			case ($urandom_range(0, 4))
				0: cells = 1;
				1: cells = 4096;
				2: cells = 4095;
				3: cells = $urandom_range(16, 128);
				default: cells = $urandom_range(1, 4096);
			endcase
			set_mode(1'($urandom_range(0, 1)), cells);
			no_idle = (phases_run % 4 == 2);
			random_sequence();
			random_sequence();
			no_idle = 1'b0;
			phases_run++;
		end
	endtask

	// stimulus
	initial begin
		arst_n             <= 1'b0;
		items.valid        <= 1'b0;
		items.operation    <= iis_pkg::OP_CLEAR;
		items.global_index <= '0;
		cfg.valid          <= 1'b0;
		cfg.index          <= iis_pkg::CFG_REF_REMOTE;
		cfg.data           <= '0;
		probe_remote = 1'b0;
		cell_limit   = iis_pkg::ACTIVE_RESET;
		wipe_tables();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_cell_limit();
		test_random_traffic();

		wait_drained(1'b0);
		repeat (20) @(posedge clk);
		$display("%0d requests sent (%0d table clears), %0d descriptor records checked",
			requests_sent, clears_sent, records_seen);
		$display("directed cases, active cell limit, %0d random phases", phases_run);
		if (errors == 0)
			$display("index_intersection_segmenter: match");
		else
			$display("index_intersection_segmenter: mismatch");
		$finish;
	end

endmodule
